[hdl/assert_macros.svh]
// assertion macros used by pneumatic_lifter_sequencer
// no dependencies; each use expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PLS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pls_pkg.sv]
// codes and constants of the pneumatic lifter sequencer
// no dependencies; used by pneumatic_lifter_sequencer and its testbench
package pls_pkg;

    typedef logic [2:0] demand_t;
    typedef logic [2:0] position_t;
    typedef logic [1:0] action_t;
    typedef logic [1:0] rewrite_t;
    typedef logic [3:0] message_t;

    // demand codes
    localparam demand_t DMD_OFF  = 3'd0;
    localparam demand_t DMD_DOWN = 3'd1;
    localparam demand_t DMD_UP   = 3'd2;
    localparam demand_t DMD_STOP = 3'd3;
    localparam demand_t DMD_EUP  = 3'd4;

    // position codes
    localparam position_t POS_ENGAGED = 3'd0;
    localparam position_t POS_RAISED  = 3'd1;
    localparam position_t POS_MOVING  = 3'd2;
    localparam position_t POS_ERROR   = 3'd3;
    localparam position_t POS_INIT    = 3'd4;

    // action codes
    localparam action_t ACT_RAISING  = 2'd0;
    localparam action_t ACT_LOWERING = 2'd1;
    localparam action_t ACT_IDLE     = 2'd2;
    localparam action_t ACT_ERAISE   = 2'd3;

    // demand rewrite codes
    localparam rewrite_t RW_NONE = 2'd0;
    localparam rewrite_t RW_OFF  = 2'd1;
    localparam rewrite_t RW_EUP  = 2'd2;

    // message codes
    localparam message_t MSG_ESTOP        = 4'd0;
    localparam message_t MSG_AIR_FAIL     = 4'd1;
    localparam message_t MSG_POWER_OFF    = 4'd2;
    localparam message_t MSG_UP_ENGAGED   = 4'd3;
    localparam message_t MSG_NO_MOVE      = 4'd4;
    localparam message_t MSG_IDLE         = 4'd5;
    localparam message_t MSG_DOWN_RAISED  = 4'd6;
    localparam message_t MSG_IDLE_FAIL    = 4'd7;
    localparam message_t MSG_MOVING_DOWN  = 4'd8;
    localparam message_t MSG_MOVING_UP    = 4'd9;
    localparam message_t MSG_EMERGENCY_UP = 4'd10;
    localparam message_t MSG_STUCK        = 4'd11;
    localparam message_t MSG_BAD_SWITCH   = 4'd12;

    // configuration register index (byte address / 4) and reset value
    localparam logic       REG_MOVE_LIMIT   = 1'b0;
    localparam logic [7:0] MOVE_LIMIT_RESET = 8'd20;

endpackage

[hdl/pneumatic_lifter_sequencer.sv]
// pneumatic lifter sequencer top level: input stage, decision logic, result stage
// depends on pls_pkg and assert_macros.svh
//
//  channel   | ports                      | direction | handshake
//  ----------+----------------------------+-----------+------------------------------
//  input     | s_valid/s_ready, s_*       | in        | valid/ready, one event per item
//  result    | m_valid/m_ready, m_*       | out       | valid/ready, one result per item
//  config    | psel/penable/pwrite/paddr  | in        | apb-style, pready tied high
//
//  a result becomes valid when its item moves on from the input register to
//  the result register, through the single decision stage; one item can be
//  accepted every cycle unless a stalled result leaves both registers full
//  aresetn is synchronous and active low; it clears handshake state, the
//  sequencer state and move_limit (back to 20)
//  a stalled result holds the result register, and the input register still
//  takes one more item before s_ready drops
`include "assert_macros.svh"

module pneumatic_lifter_sequencer #(
    parameter int COUNT_WIDTH = 8  // moving counter width, 4 to 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    // input items
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [2:0]             s_demand,
    input  logic                   s_raised_switch,
    input  logic                   s_engaged_switch,
    input  logic                   s_interlock_trip,
    input  logic                   s_upstream_pressure_good,
    input  logic                   s_downstream_pressure_good,
    input  logic                   s_simulating,
    input  logic                   s_turret_power_on,

    // result items
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_raise_valve,
    output logic                   m_lower_valve,
    output logic [2:0]             m_position_report,
    output logic                   m_turret_hold,
    output logic [1:0]             m_demand_rewrite,
    output logic [3:0]             m_message_code,
    output logic                   m_error_flag,
    output logic                   m_rearm_timer,
    output logic [COUNT_WIDTH-1:0] m_move_count,

    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // compare width covers both the counter and the 8-bit limit
    localparam int CMP_W = COUNT_WIDTH + 8;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    // ---------------- configuration ----------------
    logic [7:0] limit_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == pls_pkg::REG_MOVE_LIMIT);
    // register 0 is the only one; addresses with paddr[2] set read as zero
    assign prdata = (paddr[2] == pls_pkg::REG_MOVE_LIMIT) ? {24'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= pls_pkg::MOVE_LIMIT_RESET;
        end else if (cfg_wr) begin
            limit_reg <= pwdata[7:0];
        end
    end

    // ---------------- handshake and pipeline control ----------------
    logic in_valid_reg;
    logic out_valid_reg;
    logic adv;      // item moves from input register to result register
    logic s_fire;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end
            if (adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- input register (payload, no reset) ----------------
    pls_pkg::demand_t in_dmd_reg;
    logic             in_raised_reg;
    logic             in_engaged_reg;
    logic             in_trip_reg;
    logic             in_up_ok_reg;
    logic             in_down_ok_reg;
    logic             in_sim_reg;
    logic             in_power_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_dmd_reg     <= s_demand;
            in_raised_reg  <= s_raised_switch;
            in_engaged_reg <= s_engaged_switch;
            in_trip_reg    <= s_interlock_trip;
            in_up_ok_reg   <= s_upstream_pressure_good;
            in_down_ok_reg <= s_downstream_pressure_good;
            in_sim_reg     <= s_simulating;
            in_power_reg   <= s_turret_power_on;
        end
    end

    // ---------------- sequencer state ----------------
    pls_pkg::action_t       act_reg, act_next;
    pls_pkg::position_t     last_pos_reg, last_pos_next;
    pls_pkg::demand_t       last_dmd_reg, last_dmd_next;
    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next;
    pls_pkg::position_t     held_pos_reg, held_pos_next;
    logic                   held_hold_reg, held_hold_next;

    // per-item results
    logic                  raise_next;
    logic                  lower_next;
    pls_pkg::rewrite_t     rw_next;
    pls_pkg::message_t     msg_next;
    logic                  err_next;
    logic                  rearm_next;

    // ---------------- decision logic ----------------
    logic                   shut;
    pls_pkg::message_t      shut_msg;
    pls_pkg::position_t     pos;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   timeout;
    pls_pkg::demand_t       dmd_eff;
    pls_pkg::action_t       act_tmp;

    // shutdown conditions, highest priority first
    always_comb begin
        shut     = 1'b1;
        shut_msg = pls_pkg::MSG_ESTOP;
        if (in_trip_reg || in_dmd_reg == pls_pkg::DMD_STOP) begin
            shut_msg = pls_pkg::MSG_ESTOP;
        end else if (!in_up_ok_reg || !in_down_ok_reg) begin
            shut_msg = pls_pkg::MSG_AIR_FAIL;
        end else if (!in_sim_reg && !in_power_reg && in_dmd_reg != pls_pkg::DMD_OFF) begin
            shut_msg = pls_pkg::MSG_POWER_OFF;
        end else begin
            shut = 1'b0;
        end
    end

    // switch pair decode
    always_comb begin
        case ({in_raised_reg, in_engaged_reg})
            2'b00:   pos = pls_pkg::POS_MOVING;
            2'b01:   pos = pls_pkg::POS_ENGAGED;
            2'b10:   pos = pls_pkg::POS_RAISED;
            default: pos = pls_pkg::POS_ERROR;
        endcase
    end

    // saturating move counter and timeout against the limit
    assign cnt_inc = (cnt_reg != CNT_MAX) ? cnt_reg + 1'b1 : cnt_reg;
    assign timeout = CMP_W'(cnt_inc) >= CMP_W'(limit_reg);

    always_comb begin
        act_next       = act_reg;
        last_pos_next  = last_pos_reg;
        last_dmd_next  = last_dmd_reg;
        cnt_next       = cnt_reg;
        held_pos_next  = held_pos_reg;
        held_hold_next = held_hold_reg;
        raise_next     = 1'b0;
        lower_next     = 1'b0;
        rw_next        = pls_pkg::RW_NONE;
        msg_next       = shut_msg;
        err_next       = 1'b0;
        rearm_next     = 1'b0;
        dmd_eff        = in_dmd_reg;
        act_tmp        = act_reg;

        if (shut) begin
            // valves closed, position and turret hold keep their last value
            act_next = pls_pkg::ACT_IDLE;
            rw_next  = pls_pkg::RW_OFF;
            err_next = 1'b1;
        end else begin
            case (pos)
                pls_pkg::POS_ENGAGED: begin
                    last_pos_next  = pos;
                    held_pos_next  = pls_pkg::POS_ENGAGED;
                    cnt_next       = '0;
                    held_hold_next = 1'b1;
                    if (in_dmd_reg == pls_pkg::DMD_UP) begin
                        msg_next   = pls_pkg::MSG_UP_ENGAGED;
                        raise_next = 1'b1;
                        act_next   = pls_pkg::ACT_RAISING;
                        rearm_next = 1'b1;
                    end else if (in_dmd_reg == pls_pkg::DMD_OFF &&
                                 last_dmd_reg == pls_pkg::DMD_UP) begin
                        // raise was requested but the lifter never left
                        msg_next      = pls_pkg::MSG_NO_MOVE;
                        act_next      = pls_pkg::ACT_IDLE;
                        rw_next       = pls_pkg::RW_OFF;
                        held_pos_next = pls_pkg::POS_ERROR;
                        err_next      = 1'b1;
                    end else begin
                        msg_next = pls_pkg::MSG_IDLE;
                        act_next = pls_pkg::ACT_IDLE;
                        rw_next  = pls_pkg::RW_OFF;
                    end
                end
                pls_pkg::POS_RAISED: begin
                    last_pos_next = pos;
                    held_pos_next = pls_pkg::POS_RAISED;
                    cnt_next      = '0;
                    if (in_dmd_reg == pls_pkg::DMD_DOWN) begin
                        msg_next       = pls_pkg::MSG_DOWN_RAISED;
                        lower_next     = 1'b1;
                        act_next       = pls_pkg::ACT_LOWERING;
                        held_hold_next = 1'b1;
                        rearm_next     = 1'b1;
                    end else if (in_dmd_reg == pls_pkg::DMD_OFF &&
                                 last_dmd_reg == pls_pkg::DMD_DOWN) begin
                        msg_next       = pls_pkg::MSG_NO_MOVE;
                        act_next       = pls_pkg::ACT_IDLE;
                        rw_next        = pls_pkg::RW_OFF;
                        held_hold_next = 1'b1;
                        held_pos_next  = pls_pkg::POS_ERROR;
                        err_next       = 1'b1;
                    end else begin
                        // raised and at rest: turret released
                        msg_next       = pls_pkg::MSG_IDLE;
                        act_next       = pls_pkg::ACT_IDLE;
                        rw_next        = pls_pkg::RW_OFF;
                        held_hold_next = 1'b0;
                        if (last_dmd_reg == pls_pkg::DMD_EUP) begin
                            msg_next = pls_pkg::MSG_IDLE_FAIL;
                            err_next = 1'b1;
                        end
                    end
                end
                pls_pkg::POS_MOVING: begin
                    cnt_next = cnt_inc;
                    if (timeout) begin
                        // any raise gives up, other actions become emergency raise
                        cnt_next = '0;
                        if (act_reg inside {pls_pkg::ACT_RAISING, pls_pkg::ACT_ERAISE}) begin
                            rw_next = pls_pkg::RW_OFF;
                            dmd_eff = pls_pkg::DMD_OFF;
                            act_tmp = pls_pkg::ACT_IDLE;
                        end else begin
                            rw_next = pls_pkg::RW_EUP;
                            dmd_eff = pls_pkg::DMD_EUP;
                            act_tmp = pls_pkg::ACT_ERAISE;
                        end
                        err_next = 1'b1;
                    end
                    held_hold_next = 1'b1;
                    last_pos_next  = pos;
                    if (dmd_eff == pls_pkg::DMD_DOWN ||
                        (dmd_eff == pls_pkg::DMD_OFF && act_tmp == pls_pkg::ACT_LOWERING)) begin
                        msg_next      = pls_pkg::MSG_MOVING_DOWN;
                        lower_next    = 1'b1;
                        act_next      = pls_pkg::ACT_LOWERING;
                        held_pos_next = pls_pkg::POS_MOVING;
                        rearm_next    = 1'b1;
                    end else if (dmd_eff == pls_pkg::DMD_UP ||
                        (dmd_eff == pls_pkg::DMD_OFF && act_tmp == pls_pkg::ACT_RAISING)) begin
                        msg_next      = pls_pkg::MSG_MOVING_UP;
                        raise_next    = 1'b1;
                        act_next      = pls_pkg::ACT_RAISING;
                        held_pos_next = pls_pkg::POS_MOVING;
                        rearm_next    = 1'b1;
                    end else if (dmd_eff == pls_pkg::DMD_EUP ||
                        (dmd_eff == pls_pkg::DMD_OFF && act_tmp == pls_pkg::ACT_ERAISE)) begin
                        msg_next      = pls_pkg::MSG_EMERGENCY_UP;
                        raise_next    = 1'b1;
                        act_next      = pls_pkg::ACT_ERAISE;
                        held_pos_next = pls_pkg::POS_MOVING;
                        rearm_next    = 1'b1;
                        err_next      = 1'b1;
                    end else begin
                        // between switches with nothing driving it
                        msg_next      = pls_pkg::MSG_STUCK;
                        act_next      = pls_pkg::ACT_IDLE;
                        held_pos_next = pls_pkg::POS_ERROR;
                        err_next      = 1'b1;
                    end
                end
                default: begin
                    // both switches actuated
                    msg_next       = pls_pkg::MSG_BAD_SWITCH;
                    act_next       = pls_pkg::ACT_IDLE;
                    held_hold_next = 1'b1;
                    last_pos_next  = pos;
                    held_pos_next  = pls_pkg::POS_ERROR;
                    err_next       = 1'b1;
                end
            endcase
            last_dmd_next = dmd_eff;
        end
    end

    // state advances with each item leaving the input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg       <= pls_pkg::ACT_IDLE;
            last_pos_reg  <= pls_pkg::POS_INIT;
            last_dmd_reg  <= pls_pkg::DMD_OFF;
            cnt_reg       <= '0;
            held_pos_reg  <= pls_pkg::POS_INIT;
            held_hold_reg <= 1'b1;
        end else if (adv) begin
            act_reg       <= act_next;
            last_pos_reg  <= last_pos_next;
            last_dmd_reg  <= last_dmd_next;
            cnt_reg       <= cnt_next;
            held_pos_reg  <= held_pos_next;
            held_hold_reg <= held_hold_next;
        end
    end

    // ---------------- result register (payload, no reset) ----------------
    logic                   out_raise_reg;
    logic                   out_lower_reg;
    pls_pkg::position_t     out_pos_reg;
    logic                   out_hold_reg;
    pls_pkg::rewrite_t      out_rw_reg;
    pls_pkg::message_t      out_msg_reg;
    logic                   out_err_reg;
    logic                   out_rearm_reg;
    logic [COUNT_WIDTH-1:0] out_cnt_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_raise_reg <= raise_next;
            out_lower_reg <= lower_next;
            out_pos_reg   <= held_pos_next;
            out_hold_reg  <= held_hold_next;
            out_rw_reg    <= rw_next;
            out_msg_reg   <= msg_next;
            out_err_reg   <= err_next;
            out_rearm_reg <= rearm_next;
            out_cnt_reg   <= cnt_next;
        end
    end

    assign m_raise_valve     = out_raise_reg;
    assign m_lower_valve     = out_lower_reg;
    assign m_position_report = out_pos_reg;
    assign m_turret_hold     = out_hold_reg;
    assign m_demand_rewrite  = out_rw_reg;
    assign m_message_code    = out_msg_reg;
    assign m_error_flag      = out_err_reg;
    assign m_rearm_timer     = out_rearm_reg;
    assign m_move_count      = out_cnt_reg;

    // ---------------- assertions ----------------
    `PLS_ASSERT_IMP(a_valves_exclusive, aclk, aresetn, out_valid_reg,
        !(out_raise_reg && out_lower_reg), "both valves driven")

    `PLS_ASSERT_IMP(a_rearm_needs_valve, aclk, aresetn, out_valid_reg && out_rearm_reg,
        out_raise_reg || out_lower_reg, "rearm requested with valves closed")

    `PLS_ASSERT_IMP(a_eup_rewrite, aclk, aresetn,
        out_valid_reg && out_rw_reg == pls_pkg::RW_EUP,
        out_raise_reg && out_msg_reg == pls_pkg::MSG_EMERGENCY_UP,
        "emergency up rewrite without emergency raise")

    `PLS_ASSERT_IMP(a_count_only_moving, aclk, aresetn, cnt_reg != '0,
        held_pos_reg == pls_pkg::POS_MOVING || held_pos_reg == pls_pkg::POS_ERROR,
        "move counter running outside moving state")

    `PLS_ASSERT_NXT(a_item_advances, aclk, aresetn, in_valid_reg && !out_valid_reg,
        out_valid_reg, "item stuck in input register")

endmodule

[bench/tb_pneumatic_lifter_sequencer.sv]
// testbench for the pneumatic lifter sequencer: directed and random lift events, result check
// depends on pls_pkg and the pneumatic_lifter_sequencer rtl; self-contained otherwise
module tb_pneumatic_lifter_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_CYCLES   = 400000;   // slowest clean run stays far below this
    localparam int PHASE_ITEMS  = 170;      // random items per move-limit phase
    localparam int NUM_PHASES   = 8;
    localparam int MAX_PRINTS   = 100;      // keep the log short on a broken build
    localparam int NUM_MESSAGES = 13;
    localparam logic [2:0] MOVE_LIMIT_ADDR = {pls_pkg::REG_MOVE_LIMIT, 2'b00};

    // one processing event as it enters the block
    typedef struct packed {
        pls_pkg::demand_t demand;
        logic    raised;
        logic    engaged;
        logic    trip;
        logic    up_ok;
        logic    down_ok;
        logic    sim;
        logic    power;
    } lift_event_t;

    // one result item as it leaves the block
    typedef struct packed {
        logic      raise_valve;
        logic      lower_valve;
        pls_pkg::position_t position;
        logic      turret_hold;
        pls_pkg::rewrite_t  rewrite;
        pls_pkg::message_t  message;
        logic      error;
        logic      rearm;
        logic [7:0] move_count;
    } lift_result_t;

    // how the two sides idle in a phase
    typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

    // lifter state tracker and expected-result store
    class lift_scoreboard;
        logic [7:0]         move_limit;
        pls_pkg::action_t   action;
        pls_pkg::demand_t   prev_demand;
        logic [7:0]         move_cnt;
        pls_pkg::position_t held_pos;
        logic               held_hold;
        lift_result_t       expected_q[$];
        int                 errors;
        int                 checked;
        int                 timeouts;
        bit [NUM_MESSAGES-1:0] msg_seen;

        function new();
            move_limit  = pls_pkg::MOVE_LIMIT_RESET;
            action      = pls_pkg::ACT_IDLE;
            prev_demand = pls_pkg::DMD_OFF;
            move_cnt    = '0;
            held_pos    = pls_pkg::POS_INIT;
            held_hold   = 1'b1;
            errors      = 0;
            checked     = 0;
            timeouts    = 0;
            msg_seen    = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the result of one accepted event and advance the state
        function void note_event(lift_event_t ev);
            lift_result_t       r;
            pls_pkg::demand_t   dmd;
            pls_pkg::position_t pos;
            logic               shut;
            r = '0;
            dmd = ev.demand;
            shut = 1'b0;
            r.rewrite = pls_pkg::RW_NONE;
            r.message = pls_pkg::MSG_ESTOP;
            if (ev.trip || dmd == pls_pkg::DMD_STOP) begin
                shut = 1'b1;
                r.message = pls_pkg::MSG_ESTOP;
            end else if (!ev.up_ok || !ev.down_ok) begin
                shut = 1'b1;
                r.message = pls_pkg::MSG_AIR_FAIL;
            end else if (!ev.sim && !ev.power && dmd != pls_pkg::DMD_OFF) begin
                shut = 1'b1;
                r.message = pls_pkg::MSG_POWER_OFF;
            end

            if (shut) begin
                // held outputs and the stored demand stay as they were
                action = pls_pkg::ACT_IDLE;
                r.rewrite = pls_pkg::RW_OFF;
                r.error = 1'b1;
            end else begin
                case ({ev.raised, ev.engaged})
                    2'b00:   pos = pls_pkg::POS_MOVING;
                    2'b01:   pos = pls_pkg::POS_ENGAGED;
                    2'b10:   pos = pls_pkg::POS_RAISED;
                    default: pos = pls_pkg::POS_ERROR;
                endcase
                case (pos)
                    pls_pkg::POS_ENGAGED: begin
                        held_pos = pls_pkg::POS_ENGAGED;
                        move_cnt = '0;
                        held_hold = 1'b1;
                        if (dmd == pls_pkg::DMD_UP) begin
                            r.message = pls_pkg::MSG_UP_ENGAGED;
                            r.raise_valve = 1'b1;
                            action = pls_pkg::ACT_RAISING;
                            r.rearm = 1'b1;
                        end else if (dmd == pls_pkg::DMD_OFF &&
                                     prev_demand == pls_pkg::DMD_UP) begin
                            r.message = pls_pkg::MSG_NO_MOVE;
                            action = pls_pkg::ACT_IDLE;
                            r.rewrite = pls_pkg::RW_OFF;
                            held_pos = pls_pkg::POS_ERROR;
                            r.error = 1'b1;
                        end else begin
                            r.message = pls_pkg::MSG_IDLE;
                            action = pls_pkg::ACT_IDLE;
                            r.rewrite = pls_pkg::RW_OFF;
                        end
                    end
                    pls_pkg::POS_RAISED: begin
                        held_pos = pls_pkg::POS_RAISED;
                        move_cnt = '0;
                        if (dmd == pls_pkg::DMD_DOWN) begin
                            r.message = pls_pkg::MSG_DOWN_RAISED;
                            r.lower_valve = 1'b1;
                            action = pls_pkg::ACT_LOWERING;
                            held_hold = 1'b1;
                            r.rearm = 1'b1;
                        end else if (dmd == pls_pkg::DMD_OFF &&
                                     prev_demand == pls_pkg::DMD_DOWN) begin
                            r.message = pls_pkg::MSG_NO_MOVE;
                            action = pls_pkg::ACT_IDLE;
                            r.rewrite = pls_pkg::RW_OFF;
                            held_hold = 1'b1;
                            held_pos = pls_pkg::POS_ERROR;
                            r.error = 1'b1;
                        end else begin
                            r.message = pls_pkg::MSG_IDLE;
                            action = pls_pkg::ACT_IDLE;
                            r.rewrite = pls_pkg::RW_OFF;
                            held_hold = 1'b0;
                            if (prev_demand == pls_pkg::DMD_EUP) begin
                                r.message = pls_pkg::MSG_IDLE_FAIL;
                                r.error = 1'b1;
                            end
                        end
                    end
                    pls_pkg::POS_MOVING: begin
                        if (move_cnt != 8'hFF)
                            move_cnt = move_cnt + 8'd1;
                        if (move_cnt >= move_limit) begin
                            // timeout: end any raise, turn anything else into emergency raise
                            move_cnt = '0;
                            timeouts++;
                            if (action == pls_pkg::ACT_RAISING ||
                                action == pls_pkg::ACT_ERAISE) begin
                                r.rewrite = pls_pkg::RW_OFF;
                                dmd = pls_pkg::DMD_OFF;
                                action = pls_pkg::ACT_IDLE;
                            end else begin
                                r.rewrite = pls_pkg::RW_EUP;
                                dmd = pls_pkg::DMD_EUP;
                                action = pls_pkg::ACT_ERAISE;
                            end
                            r.error = 1'b1;
                        end
                        held_hold = 1'b1;
                        if (dmd == pls_pkg::DMD_DOWN ||
                            (dmd == pls_pkg::DMD_OFF && action == pls_pkg::ACT_LOWERING)) begin
                            r.message = pls_pkg::MSG_MOVING_DOWN;
                            r.lower_valve = 1'b1;
                            action = pls_pkg::ACT_LOWERING;
                            held_pos = pls_pkg::POS_MOVING;
                            r.rearm = 1'b1;
                        end else if (dmd == pls_pkg::DMD_UP ||
                                     (dmd == pls_pkg::DMD_OFF &&
                                      action == pls_pkg::ACT_RAISING)) begin
                            r.message = pls_pkg::MSG_MOVING_UP;
                            r.raise_valve = 1'b1;
                            action = pls_pkg::ACT_RAISING;
                            held_pos = pls_pkg::POS_MOVING;
                            r.rearm = 1'b1;
                        end else if (dmd == pls_pkg::DMD_EUP ||
                                     (dmd == pls_pkg::DMD_OFF &&
                                      action == pls_pkg::ACT_ERAISE)) begin
                            r.message = pls_pkg::MSG_EMERGENCY_UP;
                            r.raise_valve = 1'b1;
                            action = pls_pkg::ACT_ERAISE;
                            held_pos = pls_pkg::POS_MOVING;
                            r.rearm = 1'b1;
                            r.error = 1'b1;
                        end else begin
                            r.message = pls_pkg::MSG_STUCK;
                            action = pls_pkg::ACT_IDLE;
                            held_pos = pls_pkg::POS_ERROR;
                            r.error = 1'b1;
                        end
                    end
                    default: begin
                        r.message = pls_pkg::MSG_BAD_SWITCH;
                        action = pls_pkg::ACT_IDLE;
                        held_hold = 1'b1;
                        held_pos = pls_pkg::POS_ERROR;
                        r.error = 1'b1;
                    end
                endcase
                prev_demand = dmd;
            end
            r.position = held_pos;
            r.turret_hold = held_hold;
            r.move_count = move_cnt;
            msg_seen[r.message] = 1'b1;
            expected_q.push_back(r);
        endfunction

        task report_mismatch(string what);
            if (errors < MAX_PRINTS)
                $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                          checked, name, got, want));
        endtask

        // compare one result against the oldest expectation
        task check_result(lift_result_t got);
            lift_result_t want;
            if (expected_q.size() == 0) begin
                report_mismatch("result item with nothing expected");
                return;
            end
            want = expected_q.pop_front();
            compare_field("raise_valve", 16'(got.raise_valve), 16'(want.raise_valve));
            compare_field("lower_valve", 16'(got.lower_valve), 16'(want.lower_valve));
            compare_field("position_report", 16'(got.position), 16'(want.position));
            compare_field("turret_hold", 16'(got.turret_hold), 16'(want.turret_hold));
            compare_field("demand_rewrite", 16'(got.rewrite), 16'(want.rewrite));
            compare_field("message_code", 16'(got.message), 16'(want.message));
            compare_field("error_flag", 16'(got.error), 16'(want.error));
            compare_field("rearm_timer", 16'(got.rearm), 16'(want.rearm));
            compare_field("move_count", 16'(got.move_count), 16'(want.move_count));
            checked++;
        endtask
    endclass

    // clock, reset and all block inputs, known from time zero
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_demand = '0;
    logic        s_raised_switch = 1'b0;
    logic        s_engaged_switch = 1'b0;
    logic        s_interlock_trip = 1'b0;
    logic        s_upstream_pressure_good = 1'b1;
    logic        s_downstream_pressure_good = 1'b1;
    logic        s_simulating = 1'b0;
    logic        s_turret_power_on = 1'b1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_raise_valve;
    logic        m_lower_valve;
    logic [2:0]  m_position_report;
    logic        m_turret_hold;
    logic [1:0]  m_demand_rewrite;
    logic [3:0]  m_message_code;
    logic        m_error_flag;
    logic        m_rearm_timer;
    logic [7:0]  m_move_count;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    lift_scoreboard sb;
    pace_t          pace = PACE_FULL;
    int             items_sent = 0;
    int             cycle_count = 0;
    int             limits_used = 1;

    pneumatic_lifter_sequencer DUT (
        .aclk                       (aclk),
        .aresetn                    (aresetn),
        .s_valid                    (s_valid),
        .s_ready                    (s_ready),
        .s_demand                   (s_demand),
        .s_raised_switch            (s_raised_switch),
        .s_engaged_switch           (s_engaged_switch),
        .s_interlock_trip           (s_interlock_trip),
        .s_upstream_pressure_good   (s_upstream_pressure_good),
        .s_downstream_pressure_good (s_downstream_pressure_good),
        .s_simulating               (s_simulating),
        .s_turret_power_on          (s_turret_power_on),
        .m_valid                    (m_valid),
        .m_ready                    (m_ready),
        .m_raise_valve              (m_raise_valve),
        .m_lower_valve              (m_lower_valve),
        .m_position_report          (m_position_report),
        .m_turret_hold              (m_turret_hold),
        .m_demand_rewrite           (m_demand_rewrite),
        .m_message_code             (m_message_code),
        .m_error_flag               (m_error_flag),
        .m_rearm_timer              (m_rearm_timer),
        .m_move_count               (m_move_count),
        .psel                       (psel),
        .penable                    (penable),
        .pwrite                     (pwrite),
        .paddr                      (paddr),
        .pwdata                     (pwdata),
        .prdata                     (prdata),
        .pready                     (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // cycle counter doubles as the run watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("tb_pneumatic_lifter_sequencer: errors");
            $finish;
        end
    end

    // result side back-pressure, following the pace of the current phase
    always @(posedge aclk) begin
        case (pace)
            PACE_RECV_STALLS: m_ready <= ($urandom_range(99) >= 85);
            PACE_BOTH:        m_ready <= ($urandom_range(99) >= 17);
            default:          m_ready <= 1'b1;
        endcase
    end

    // monitor: everything is sampled at the clock edge, before the block updates;
    // results are checked before a new item is noted, though latency keeps them apart anyway
    always @(posedge aclk) begin : monitor
        lift_result_t got;
        lift_event_t  ev;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got.raise_valve = m_raise_valve;
                got.lower_valve = m_lower_valve;
                got.position    = m_position_report;
                got.turret_hold = m_turret_hold;
                got.rewrite     = m_demand_rewrite;
                got.message     = m_message_code;
                got.error       = m_error_flag;
                got.rearm       = m_rearm_timer;
                got.move_count  = m_move_count;
                sb.check_result(got);
            end
            if (s_valid && s_ready) begin
                ev.demand  = s_demand;
                ev.raised  = s_raised_switch;
                ev.engaged = s_engaged_switch;
                ev.trip    = s_interlock_trip;
                ev.up_ok   = s_upstream_pressure_good;
                ev.down_ok = s_downstream_pressure_good;
                ev.sim     = s_simulating;
                ev.power   = s_turret_power_on;
                sb.note_event(ev);
            end
        end
    end

    // healthy event: air good, no trip, turret powered (simulation flag free)
    function automatic lift_event_t clean_event(pls_pkg::demand_t d, logic r, logic e);
        lift_event_t ev;
        ev.demand  = d;
        ev.raised  = r;
        ev.engaged = e;
        ev.trip    = 1'b0;
        ev.up_ok   = 1'b1;
        ev.down_ok = 1'b1;
        ev.sim     = 1'($urandom_range(1));
        ev.power   = 1'b1;
        return ev;
    endfunction

    // anything at all, biased so that healthy events still dominate
    function automatic lift_event_t noise_event();
        lift_event_t ev;
        ev.demand  = pls_pkg::demand_t'($urandom_range(7));
        ev.raised  = 1'($urandom_range(1));
        ev.engaged = 1'($urandom_range(1));
        ev.trip    = ($urandom_range(99) < 15);
        ev.up_ok   = ($urandom_range(99) >= 12);
        ev.down_ok = ($urandom_range(99) >= 12);
        ev.sim     = 1'($urandom_range(1));
        ev.power   = ($urandom_range(99) >= 25);
        return ev;
    endfunction

    // a single fault in the middle of a movement
    function automatic lift_event_t fault_event(pls_pkg::demand_t d);
        lift_event_t ev;
        ev = clean_event(d, 1'b0, 1'b0);
        case ($urandom_range(3))
            0: ev.trip = 1'b1;
            1: ev.demand = pls_pkg::DMD_STOP;
            2: begin
                ev.up_ok = 1'($urandom_range(1));
                ev.down_ok = ~ev.up_ok;
            end
            default: begin
                ev.sim = 1'b0;
                ev.power = 1'b0;
            end
        endcase
        return ev;
    endfunction

    // present one item, with a random gap first in paces that have gaps, and wait for its acceptance;
    // valid stays high into the next call unless that call starts with a gap
    task automatic send_event(lift_event_t ev);
        int gap_pct;
        gap_pct = (pace == PACE_SEND_GAPS) ? 85 : (pace == PACE_BOTH) ? 17 : 0;
        if ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_valid                    <= 1'b1;
        s_demand                   <= ev.demand;
        s_raised_switch            <= ev.raised;
        s_engaged_switch           <= ev.engaged;
        s_interlock_trip           <= ev.trip;
        s_upstream_pressure_good   <= ev.up_ok;
        s_downstream_pressure_good <= ev.down_ok;
        s_simulating               <= ev.sim;
        s_turret_power_on          <= ev.power;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // stop sending and let every expected result come out
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // apb write of move_limit, then read it back
    task automatic set_move_limit(logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MOVE_LIMIT_ADDR;
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // write lands at this edge
        sb.move_limit = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, value})
            sb.report_mismatch($sformatf("move_limit read back %0h want %0h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        limits_used++;
    endtask

    // short directed walk through every branch and special case but the timeout
    task automatic directed_events();
        lift_event_t ev;
        // a stop path before anything else: held outputs still show init
        ev = clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b1);
        ev.trip = 1'b1;
        send_event(ev);
        send_event(clean_event(pls_pkg::DMD_STOP, 1'b0, 1'b1));
        ev = clean_event(pls_pkg::DMD_UP, 1'b0, 1'b1);
        ev.up_ok = 1'b0;
        send_event(ev);
        ev = clean_event(pls_pkg::DMD_UP, 1'b0, 1'b1);
        ev.down_ok = 1'b0;
        send_event(ev);
        // power off blocks a demand, but not an off demand, and not when simulating
        ev = clean_event(pls_pkg::DMD_UP, 1'b0, 1'b1);
        ev.sim = 1'b0;
        ev.power = 1'b0;
        send_event(ev);
        ev.demand = pls_pkg::DMD_OFF;
        send_event(ev);
        ev.demand = pls_pkg::DMD_UP;
        ev.sim = 1'b1;
        send_event(ev);
        // a full raise, then a full lower
        send_event(clean_event(pls_pkg::DMD_UP, 1'b0, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b1, 1'b0));
        send_event(clean_event(pls_pkg::DMD_DOWN, 1'b1, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b1));
        // demand dropped without the lifter leaving either end
        send_event(clean_event(pls_pkg::DMD_UP, 1'b0, 1'b1));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b1));
        send_event(clean_event(pls_pkg::DMD_DOWN, 1'b1, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b1, 1'b0));
        // emergency raise, then idle at the top after it
        send_event(clean_event(pls_pkg::DMD_EUP, 1'b0, 1'b0));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b1, 1'b0));
        // both switches made, then moving with nothing going on
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b1, 1'b1));
        send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b0));
        // unrecognized demands at each position, the last one unpowered
        send_event(clean_event(pls_pkg::demand_t'(pls_pkg::DMD_EUP + 3'd1), 1'b0, 1'b1));
        send_event(clean_event(pls_pkg::demand_t'(pls_pkg::DMD_EUP + 3'd2), 1'b0, 1'b0));
        ev = clean_event(pls_pkg::demand_t'(pls_pkg::DMD_EUP + 3'd3), 1'b1, 1'b0);
        ev.sim = 1'b0;
        ev.power = 1'b0;
        send_event(ev);
    endtask

    // one travel from one end to the other, with mostly healthy content
    task automatic travel_episode(output int count);
        logic             going_up;
        pls_pkg::demand_t dir;
        int               lim;
        int               moves;
        int               pick;
        going_up = 1'($urandom_range(1));
        dir = going_up ? pls_pkg::DMD_UP : pls_pkg::DMD_DOWN;
        lim = int'(sb.move_limit);
        send_event(going_up ? clean_event(pls_pkg::DMD_UP, 1'b0, 1'b1)
                            : clean_event(pls_pkg::DMD_DOWN, 1'b1, 1'b0));
        count = 1;
        // a good share of travels run into the movement timeout
        if ($urandom_range(99) < 30)
            moves = lim + $urandom_range(3);
        else
            moves = $urandom_range(lim + 2);
        repeat (moves) begin
            pick = $urandom_range(99);
            if (pick < 6)
                send_event(fault_event(dir));
            else if (pick < 10)
                send_event(clean_event(pls_pkg::DMD_EUP, 1'b0, 1'b0));
            else if (pick < 14)
                send_event(clean_event(pls_pkg::demand_t'($urandom_range(7)), 1'b0, 1'b0));
            else if (pick < 57)
                send_event(clean_event(dir, 1'b0, 1'b0));
            else
                send_event(clean_event(pls_pkg::DMD_OFF, 1'b0, 1'b0));
            count++;
        end
        // arrival, usually at the far end with the demand dropped
        pick = $urandom_range(99);
        if (pick < 60)
            send_event(clean_event(pls_pkg::DMD_OFF, going_up, ~going_up));
        else if (pick < 80)
            send_event(clean_event(dir, going_up, ~going_up));
        else
            send_event(clean_event(pls_pkg::demand_t'($urandom_range(7)),
                                   1'($urandom_range(1)), 1'($urandom_range(1))));
        send_event(clean_event(pls_pkg::DMD_OFF, going_up, ~going_up));
        count += 2;
    endtask

    task automatic random_phase(int budget);
        int sent;
        int n;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(99) < 25) begin
                n = $urandom_range(1, 6);
                repeat (n) send_event(noise_event());
            end else begin
                travel_episode(n);
            end
            sent += n;
        end
    endtask

    initial begin
        int phase;
        int lim;
        sb = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        pace = PACE_BOTH;
        directed_events();
        wait_drain();

        // phase 0 runs on the reset limit; the rest write the limit first,
        // covering the smallest, the largest, zero and a few middle values
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            pace = pace_t'(phase % 4);
            case (phase)
                0: lim = -1;
                1: lim = 1;
                2: lim = 255;
                3: lim = 0;
                4: lim = 6;
                5: lim = $urandom_range(2, 30);
                6: lim = $urandom_range(31, 90);
                default: lim = int'(pls_pkg::MOVE_LIMIT_RESET);
            endcase
            if (lim >= 0)
                set_move_limit(lim[7:0]);
            random_phase(PHASE_ITEMS);
            wait_drain();
        end

        repeat (8) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d lift events under %0d move limits, %0d movement timeouts",
                 items_sent, limits_used, sb.timeouts);
        $display("%0d results checked, %0d of %0d message codes seen, %0d mismatches",
                 sb.checked, $countones(sb.msg_seen), NUM_MESSAGES, sb.errors);
        if (sb.errors == 0) begin
            $display("tb_pneumatic_lifter_sequencer: clean");
        end else begin
            $display("tb_pneumatic_lifter_sequencer: errors");
        end
        $finish;
    end

endmodule
